@@ sv/plob_pkg.sv @@
// plob_pkg: shared types and constants for the price level order book
// no dependencies
package plob_pkg;

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_MODIFY = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_EXEC   = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the incoming item
        logic clear_book;  // invalidate all levels
        logic scan_start;  // reset scan accumulators
        logic scan_step;   // examine one entry of each side
        logic apply;       // write the table update
        logic tob_step;    // latch top of book, start divider
        logic div_step;    // one quotient bit
        logic done;        // drive result strobe
    } plob_cmd_t;

    // status back from datapath
    typedef struct packed {
        logic scan_last;
        logic div_last;
    } plob_sts_t;

endpackage

@@ sv/plob_ctrl.sv @@
// plob_ctrl: sequencer for one order book message
// depends on plob_pkg
module plob_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         action,
    output logic               busy,
    output plob_pkg::plob_cmd_t cmd,
    input  plob_pkg::plob_sts_t sts
);
    import plob_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_FIND, S_APPLY, S_SCAN, S_TOB, S_DIV, S_OUT} state_t;
    state_t state_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:  if (start) state_reg <= S_FIND;
                S_FIND:  if (sts.scan_last) state_reg <= S_APPLY;
                S_APPLY: state_reg <= S_SCAN;
                S_SCAN:  if (sts.scan_last) state_reg <= S_TOB;
                S_TOB:   state_reg <= S_DIV;
                S_DIV:   if (sts.div_last) state_reg <= S_OUT;
                S_OUT:   state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);

    // command decode
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                cmd.scan_start = start;
                cmd.clear_book = start && (action == ACT_CLEAR);
            end
            S_FIND:  cmd.scan_step = 1'b1;
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                cmd.scan_start = 1'b1;
            end
            S_SCAN:  cmd.scan_step = 1'b1;
            S_TOB:   cmd.tob_step = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_OUT:   cmd.done = 1'b1;
            default: cmd = '0;
        endcase
    end
endmodule

@@ sv/plob_dp.sv @@
// plob_dp: level tables, scan unit and imbalance divider
// depends on plob_pkg
module plob_dp #(
    parameter int LEVELS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  plob_pkg::plob_cmd_t cmd,
    output plob_pkg::plob_sts_t sts,
    input  logic [2:0]          action,
    input  logic                side,
    input  logic signed [31:0]  price,
    input  logic [31:0]         quantity,
    input  logic [63:0]         timestamp,
    output logic                done,
    output logic signed [31:0]  best_bid_price,
    output logic [31:0]         best_bid_qty,
    output logic signed [31:0]  best_ask_price,
    output logic [31:0]         best_ask_qty,
    output logic signed [32:0]  spread_ticks,
    output logic signed [15:0]  imbalance_q14,
    output logic [6:0]          bid_level_count,
    output logic [6:0]          ask_level_count,
    output logic [63:0]         last_time,
    output logic [31:0]         messages_seen,
    output logic                table_full
);
    import plob_pkg::*;

    localparam int IW = $clog2(LEVELS);
    localparam int CW = $clog2(LEVELS + 1);

    // level memories: bid at index 0, ask at index 1
    logic [31:0] price_mem [2][LEVELS];
    logic [31:0] size_mem  [2][LEVELS];
    logic [LEVELS-1:0] valid_reg [2];

    // captured item
    logic [2:0]  act_reg;
    logic        side_reg;
    logic [31:0] price_reg;
    logic [31:0] qty_reg;
    logic [63:0] time_reg;
    logic [31:0] total_reg;

    // scan state
    logic [IW-1:0] idx_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [31:0]   hit_size_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic          bb_ok_reg, ba_ok_reg;
    logic signed [31:0] bbp_reg, bap_reg;
    logic [31:0]   bbs_reg, bas_reg;
    logic [CW-1:0] nb_reg, na_reg;
    logic          full_reg;

    // divider
    logic [48:0] rem_reg;
    logic [32:0] den_reg;
    logic [14:0] quo_reg;
    logic [3:0]  dcnt_reg;
    logic        neg_reg;
    logic        imb_on_reg;

    // registered table read, one entry of each side per cycle
    logic [31:0]   rd_price_reg [2];
    logic [31:0]   rd_size_reg  [2];
    logic          rd_valid_reg [2];
    logic [IW-1:0] rd_idx_reg;
    logic          rd_en_reg;

    assign sts.scan_last = rd_en_reg && (rd_idx_reg == IW'(LEVELS - 1));
    assign sts.div_last  = (dcnt_reg == 4'd0);

    // entry read for both sides, data in the cycle after the index
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < 2; s++)
        begin
            rd_price_reg[s] <= price_mem[s][idx_reg];
            rd_size_reg[s]  <= size_mem[s][idx_reg];
            rd_valid_reg[s] <= valid_reg[s][idx_reg];
        end
        rd_idx_reg <= idx_reg;
    end

    // captured item and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            total_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (action <= ACT_EXEC)
            begin
                time_reg  <= timestamp;
                total_reg <= total_reg + 32'd1;
            end
            else if (action == ACT_CLEAR)
            begin
                time_reg  <= '0;
                total_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= action;
            side_reg  <= side;
            price_reg <= price;
            qty_reg   <= quantity;
        end
    end

    // valid flags and table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= '0;
            valid_reg[1] <= '0;
            full_reg     <= 1'b0;
        end
        else if (cmd.clear_book)
        begin
            valid_reg[0] <= '0;
            valid_reg[1] <= '0;
            full_reg     <= 1'b0;
        end
        else if (cmd.load)
        begin
            full_reg <= 1'b0;
        end
        else if (cmd.apply && act_reg <= ACT_EXEC)
        begin
            if (hit_reg)
            begin
                if ((act_reg == ACT_MODIFY && qty_reg == 32'd0) || act_reg == ACT_REMOVE
                    || (act_reg == ACT_EXEC && hit_size_reg <= qty_reg))
                    valid_reg[side_reg][hit_idx_reg] <= 1'b0;
            end
            else if (act_reg == ACT_ADD || (act_reg == ACT_MODIFY && qty_reg != 32'd0))
            begin
                if (free_reg)
                    valid_reg[side_reg][free_idx_reg] <= 1'b1;
                else
                    full_reg <= 1'b1;
            end
        end
    end

    logic [32:0] add_sum;
    assign add_sum = {1'b0, hit_size_reg} + {1'b0, qty_reg};

    // price and size memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.apply && act_reg <= ACT_EXEC)
        begin
            if (hit_reg)
            begin
                if (act_reg == ACT_ADD)
                    size_mem[side_reg][hit_idx_reg] <= add_sum[32] ? 32'hFFFF_FFFF
                                                                   : add_sum[31:0];
                else if (act_reg == ACT_MODIFY)
                    size_mem[side_reg][hit_idx_reg] <= qty_reg;
                else if (act_reg == ACT_EXEC)
                    size_mem[side_reg][hit_idx_reg] <= hit_size_reg - qty_reg;
            end
            else if ((act_reg == ACT_ADD || (act_reg == ACT_MODIFY && qty_reg != 32'd0))
                     && free_reg)
            begin
                price_mem[side_reg][free_idx_reg] <= price_reg;
                size_mem[side_reg][free_idx_reg]  <= qty_reg;
            end
        end
    end

    // scan: level search, then best level search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            rd_en_reg <= 1'b0;
        end
        else
        begin
            rd_en_reg <= cmd.scan_step;
            if (cmd.scan_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            bb_ok_reg <= 1'b0;
            ba_ok_reg <= 1'b0;
            nb_reg    <= '0;
            na_reg    <= '0;
        end
        else if (cmd.scan_step && rd_en_reg)
        begin
            // level lookup on the message side
            if (!hit_reg && rd_valid_reg[side_reg] && rd_price_reg[side_reg] == price_reg)
            begin
                hit_reg      <= 1'b1;
                hit_idx_reg  <= rd_idx_reg;
                hit_size_reg <= rd_size_reg[side_reg];
            end
            if (!free_reg && !rd_valid_reg[side_reg])
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
            // best bid
            if (rd_valid_reg[0])
            begin
                nb_reg <= nb_reg + CW'(1);
                if (!bb_ok_reg || $signed(rd_price_reg[0]) > bbp_reg)
                begin
                    bb_ok_reg <= 1'b1;
                    bbp_reg   <= rd_price_reg[0];
                    bbs_reg   <= rd_size_reg[0];
                end
            end
            // best ask
            if (rd_valid_reg[1])
            begin
                na_reg <= na_reg + CW'(1);
                if (!ba_ok_reg || $signed(rd_price_reg[1]) < bap_reg)
                begin
                    ba_ok_reg <= 1'b1;
                    bap_reg   <= rd_price_reg[1];
                    bas_reg   <= rd_size_reg[1];
                end
            end
        end
    end

    // imbalance divider, restoring, one quotient bit per cycle
    // dividend is mag shifted up by 14, 15 quotient bits so a one-sided total gives 16384
    logic [32:0] mag;
    logic [48:0] trial;
    assign mag   = (bbs_reg >= bas_reg) ? {1'b0, bbs_reg - bas_reg} : {1'b0, bas_reg - bbs_reg};
    assign trial = {rem_reg[47:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.tob_step)
        begin
            dcnt_reg <= 4'd15;
        end
        else if (cmd.div_step && dcnt_reg != 4'd0)
        begin
            dcnt_reg <= dcnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tob_step)
        begin
            rem_reg    <= {2'd0, mag, 14'd0};
            den_reg    <= {1'b0, bbs_reg} + {1'b0, bas_reg};
            quo_reg    <= '0;
            neg_reg    <= bbs_reg < bas_reg;
            imb_on_reg <= bb_ok_reg && ba_ok_reg && (bbs_reg != 32'd0 || bas_reg != 32'd0);
        end
        else if (cmd.div_step && dcnt_reg != 4'd0)
        begin
            if (trial[48:15] >= {1'b0, den_reg})
            begin
                rem_reg <= {trial[48:15] - {1'b0, den_reg}, trial[14:0]};
                quo_reg <= {quo_reg[13:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[13:0], 1'b0};
            end
        end
    end

    // result fields
    logic signed [15:0] q16;
    assign q16 = {1'b0, quo_reg};

    assign done            = cmd.done;
    assign best_bid_price  = bb_ok_reg ? bbp_reg : 32'sd0;
    assign best_bid_qty    = bb_ok_reg ? bbs_reg : 32'd0;
    assign best_ask_price  = ba_ok_reg ? bap_reg : 32'sd0;
    assign best_ask_qty    = ba_ok_reg ? bas_reg : 32'd0;
    assign spread_ticks    = (bb_ok_reg && ba_ok_reg)
                             ? (33'(bap_reg) - 33'(bbp_reg)) : 33'sd0;
    assign imbalance_q14   = !imb_on_reg ? 16'sd0 : (neg_reg ? -q16 : q16);
    assign bid_level_count = 7'(nb_reg);
    assign ask_level_count = 7'(na_reg);
    assign last_time       = time_reg;
    assign messages_seen   = total_reg;
    assign table_full      = full_reg;
endmodule

@@ sv/price_level_order_book.sv @@
// price_level_order_book: top level, controller plus datapath
// depends on plob_pkg, plob_ctrl, plob_dp
//
// Each item goes from the accepting edge to the done strobe in these steps:
// one pass over the level tables to locate the level and a free entry, a write
// step, a second pass to find best bid and ask and count levels (the table read
// is registered), a step to latch the top of book, then 15 divider steps for the
// imbalance. busy is low again the cycle after done; the block takes no new item
// until the last one is through. The result fields are valid only while done is
// high and must be captured then; the receiver cannot stall the block.
module price_level_order_book #(
    parameter int LEVELS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         action,
    input  logic               side,
    input  logic signed [31:0] price,
    input  logic [31:0]        quantity,
    input  logic [63:0]        timestamp,
    output logic               done,
    output logic signed [31:0] best_bid_price,
    output logic [31:0]        best_bid_qty,
    output logic signed [31:0] best_ask_price,
    output logic [31:0]        best_ask_qty,
    output logic signed [32:0] spread_ticks,
    output logic signed [15:0] imbalance_q14,
    output logic [6:0]         bid_level_count,
    output logic [6:0]         ask_level_count,
    output logic [63:0]        last_time,
    output logic [31:0]        messages_seen,
    output logic               table_full
);
    import plob_pkg::*;

    plob_cmd_t cmd;
    plob_sts_t sts;

    // sequencer
    plob_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .busy   (busy),
        .cmd    (cmd),
        .sts    (sts)
    );

    // tables and arithmetic
    plob_dp #(.LEVELS(LEVELS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .action          (action),
        .side            (side),
        .price           (price),
        .quantity        (quantity),
        .timestamp       (timestamp),
        .done            (done),
        .best_bid_price  (best_bid_price),
        .best_bid_qty    (best_bid_qty),
        .best_ask_price  (best_ask_price),
        .best_ask_qty    (best_ask_qty),
        .spread_ticks    (spread_ticks),
        .imbalance_q14   (imbalance_q14),
        .bid_level_count (bid_level_count),
        .ask_level_count (ask_level_count),
        .last_time       (last_time),
        .messages_seen   (messages_seen),
        .table_full      (table_full)
    );
endmodule

@@ tb/price_level_order_book_checker.sv @@
// price_level_order_book_checker: watches the item and result ports of the order book,
// keeps its own copy of both level tables, predicts each top-of-book report and compares
// depends on plob_pkg for the action codes and on the block's port list
module price_level_order_book_checker #(
    parameter int LEVELS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         action,
    input  logic               side,
    input  logic signed [31:0] price,
    input  logic [31:0]        quantity,
    input  logic [63:0]        timestamp,
    input  logic               done,
    input  logic signed [31:0] best_bid_price,
    input  logic [31:0]        best_bid_qty,
    input  logic signed [31:0] best_ask_price,
    input  logic [31:0]        best_ask_qty,
    input  logic signed [32:0] spread_ticks,
    input  logic signed [15:0] imbalance_q14,
    input  logic [6:0]         bid_level_count,
    input  logic [6:0]         ask_level_count,
    input  logic [63:0]        last_time,
    input  logic [31:0]        messages_seen,
    input  logic               table_full,
    output int                 fail_count,
    output int                 tob_pending,
    output int                 tob_checked,
    output int                 drops_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import plob_pkg::*;

    typedef struct {
        logic signed [31:0] bid_px;
        logic [31:0]        bid_sz;
        logic signed [31:0] ask_px;
        logic [31:0]        ask_sz;
        logic signed [32:0] spread;
        logic signed [15:0] imb;
        logic [6:0]         nbid;
        logic [6:0]         nask;
        logic [63:0]        ltime;
        logic [31:0]        msgs;
        logic               full;
    } tob_t;

    // model tables, index 0 bid, 1 ask
    logic signed [31:0] lvl_px [2][LEVELS];
    logic [31:0]        lvl_sz [2][LEVELS];
    bit                 lvl_ok [2][LEVELS];
    logic [63:0]        cur_time;
    logic [31:0]        cur_msgs;
    tob_t               tob_q[$];

    // apply one item to one side, returns 1 when an insert is dropped
    function automatic bit update_side(int s, logic [2:0] act, logic signed [31:0] px,
                                       logic [31:0] qty);
        int at;
        int slot;
        logic [32:0] sum;
        at = -1;
        slot = -1;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (at < 0 && lvl_ok[s][i] && lvl_px[s][i] == px) at = i;
            if (slot < 0 && !lvl_ok[s][i]) slot = i;
        end
        if (at >= 0)
        begin
            case (act)
                ACT_ADD:
                begin
                    sum = {1'b0, lvl_sz[s][at]} + qty;
                    lvl_sz[s][at] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
                ACT_MODIFY:
                begin
                    lvl_sz[s][at] = qty;
                    if (qty == 0) lvl_ok[s][at] = 0;
                end
                ACT_REMOVE: lvl_ok[s][at] = 0;
                default:
                begin
                    if (lvl_sz[s][at] > qty) lvl_sz[s][at] -= qty;
                    else lvl_ok[s][at] = 0;
                end
            endcase
            return 0;
        end
        // absent level: only add and nonzero modify insert
        if (act == ACT_ADD || (act == ACT_MODIFY && qty != 0))
        begin
            if (slot < 0) return 1;
            lvl_px[s][slot] = px;
            lvl_sz[s][slot] = qty;
            lvl_ok[s][slot] = 1;
        end
        return 0;
    endfunction

    // work out the top-of-book report after one item
    function automatic tob_t predict_tob(logic [2:0] act, logic sd, logic signed [31:0] px,
                                         logic [31:0] qty, logic [63:0] ts);
        tob_t r;
        int bb;
        int ba;
        int nb;
        int na;
        logic [63:0] bs;
        logic [63:0] as_;
        logic [63:0] mag;
        logic [63:0] q;
        r.full = 0;
        if (act < ACT_CLEAR)
        begin
            r.full = update_side(sd, act, px, qty);
            cur_time = ts;
            cur_msgs = cur_msgs + 1;
        end
        else if (act == ACT_CLEAR)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                lvl_ok[0][i] = 0;
                lvl_ok[1][i] = 0;
            end
            cur_time = 0;
            cur_msgs = 0;
        end
        bb = -1;
        ba = -1;
        nb = 0;
        na = 0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (lvl_ok[0][i])
            begin
                nb++;
                if (bb < 0 || lvl_px[0][i] > lvl_px[0][bb]) bb = i;
            end
            if (lvl_ok[1][i])
            begin
                na++;
                if (ba < 0 || lvl_px[1][i] < lvl_px[1][ba]) ba = i;
            end
        end
        r.bid_px = (bb >= 0) ? lvl_px[0][bb] : 32'sd0;
        r.bid_sz = (bb >= 0) ? lvl_sz[0][bb] : 32'd0;
        r.ask_px = (ba >= 0) ? lvl_px[1][ba] : 32'sd0;
        r.ask_sz = (ba >= 0) ? lvl_sz[1][ba] : 32'd0;
        r.spread = 0;
        r.imb = 0;
        if (bb >= 0 && ba >= 0)
        begin
            r.spread = 33'(r.ask_px) - 33'(r.bid_px);
            bs = r.bid_sz;
            as_ = r.ask_sz;
            if (bs + as_ != 0)
            begin
                mag = (bs >= as_) ? bs - as_ : as_ - bs;
                q = (mag << 14) / (bs + as_);
                r.imb = (bs >= as_) ? q[15:0] : -q[15:0];
            end
        end
        r.nbid = nb[6:0];
        r.nask = na[6:0];
        r.ltime = cur_time;
        r.msgs = cur_msgs;
        return r;
    endfunction

    // predict on accepted items, compare on the done strobe
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                lvl_ok[0][i] = 0;
                lvl_ok[1][i] = 0;
            end
            cur_time = 0;
            cur_msgs = 0;
            tob_q.delete();
            fail_count <= 0;
            tob_pending <= 0;
            tob_checked <= 0;
            drops_seen <= 0;
        end
        else
        begin
            tob_t e;
            int errs;
            errs = 0;
            if (done)
            begin
                if (tob_q.size() == 0)
                begin
                    $display("%0t: result with no item waiting", $time);
                    errs++;
                end
                else
                begin
                    e = tob_q.pop_front();
                    if (best_bid_price !== e.bid_px)
                    begin
                        $display("%0t: best_bid_price exp %0d got %0d", $time, e.bid_px,
                                 best_bid_price);
                        errs++;
                    end
                    if (best_bid_qty !== e.bid_sz)
                    begin
                        $display("%0t: best_bid_qty exp %0d got %0d", $time, e.bid_sz,
                                 best_bid_qty);
                        errs++;
                    end
                    if (best_ask_price !== e.ask_px)
                    begin
                        $display("%0t: best_ask_price exp %0d got %0d", $time, e.ask_px,
                                 best_ask_price);
                        errs++;
                    end
                    if (best_ask_qty !== e.ask_sz)
                    begin
                        $display("%0t: best_ask_qty exp %0d got %0d", $time, e.ask_sz,
                                 best_ask_qty);
                        errs++;
                    end
                    if (spread_ticks !== e.spread)
                    begin
                        $display("%0t: spread_ticks exp %0d got %0d", $time, e.spread,
                                 spread_ticks);
                        errs++;
                    end
                    if (imbalance_q14 !== e.imb)
                    begin
                        $display("%0t: imbalance_q14 exp %0d got %0d", $time, e.imb,
                                 imbalance_q14);
                        errs++;
                    end
                    if (bid_level_count !== e.nbid)
                    begin
                        $display("%0t: bid_level_count exp %0d got %0d", $time, e.nbid,
                                 bid_level_count);
                        errs++;
                    end
                    if (ask_level_count !== e.nask)
                    begin
                        $display("%0t: ask_level_count exp %0d got %0d", $time, e.nask,
                                 ask_level_count);
                        errs++;
                    end
                    if (last_time !== e.ltime)
                    begin
                        $display("%0t: last_time exp %h got %h", $time, e.ltime, last_time);
                        errs++;
                    end
                    if (messages_seen !== e.msgs)
                    begin
                        $display("%0t: messages_seen exp %0d got %0d", $time, e.msgs,
                                 messages_seen);
                        errs++;
                    end
                    if (table_full !== e.full)
                    begin
                        $display("%0t: table_full exp %b got %b", $time, e.full, table_full);
                        errs++;
                    end
                    if (e.full) drops_seen <= drops_seen + 1;
                end
                tob_checked <= tob_checked + 1;
            end
            if (start && !busy)
                tob_q.insert(tob_q.size(), predict_tob(action, side, price, quantity,
                                                       timestamp));
            fail_count <= fail_count + errs;
            tob_pending <= tob_q.size();
        end
    end

endmodule

@@ tb/price_level_order_book_tb.sv @@
// price_level_order_book_tb: clock, reset and item stimulus for the order book, final verdict
// depends on plob_pkg, price_level_order_book and price_level_order_book_checker
module price_level_order_book_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import plob_pkg::*;

    localparam int LEVELS = 64;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         action;
    logic               side;
    logic signed [31:0] price;
    logic [31:0]        quantity;
    logic [63:0]        timestamp;
    logic               done;
    logic signed [31:0] best_bid_price;
    logic [31:0]        best_bid_qty;
    logic signed [31:0] best_ask_price;
    logic [31:0]        best_ask_qty;
    logic signed [32:0] spread_ticks;
    logic signed [15:0] imbalance_q14;
    logic [6:0]         bid_level_count;
    logic [6:0]         ask_level_count;
    logic [63:0]        last_time;
    logic [31:0]        messages_seen;
    logic               table_full;
    int                 fail_count;
    int                 tob_pending;
    int                 tob_checked;
    int                 drops_seen;
    int                 items_sent;
    bit                 allow_gaps;

    price_level_order_book #(.LEVELS(LEVELS)) uut (.*);
    price_level_order_book_checker #(.LEVELS(LEVELS)) chk (.*);

    // clock
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    // drive one item at the falling edge and hold it until accepted
    task automatic send_item(logic [2:0] act, logic sd, logic signed [31:0] px,
                             logic [31:0] qty);
        bit was_busy;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            start = 0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        action = act;
        side = sd;
        price = px;
        quantity = qty;
        timestamp = {$urandom, $urandom};
        start = 1;
        do
        begin
            was_busy = busy;
            @(negedge clk);
        end
        while (was_busy);
        items_sent++;
    endtask

    // mostly a small pool of prices so levels hit, fill and drain
    function automatic logic signed [31:0] pick_price();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return 32'(int'($urandom_range(0, 79)) - 40);
        endcase
    endfunction

    function automatic logic [31:0] pick_qty();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 1000);
        endcase
    endfunction

    initial
    begin
        logic [2:0] act;
        int r;
        rst_n = 0;
        start = 0;
        action = ACT_ADD;
        side = 0;
        price = 0;
        quantity = 0;
        timestamp = 0;
        items_sent = 0;
        allow_gaps = 0;
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: extremes, every action and the corner cases
        send_item(ACT_ADD, 0, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(ACT_ADD, 1, 32'sh8000_0000, 32'hFFFF_FFFF);
        send_item(ACT_ADD, 0, 32'sh7FFF_FFFF, 32'd5);
        send_item(ACT_ADD, 1, 32'sh7FFF_FFFF, 32'd0);
        send_item(ACT_REMOVE, 1, 32'sh8000_0000, 32'd7);
        send_item(ACT_REMOVE, 0, 32'sh7FFF_FFFF, 32'd0);
        send_item(ACT_ADD, 0, 32'sh8000_0000, 32'd300);
        send_item(ACT_ADD, 0, -32'sd5, 32'd100);
        send_item(ACT_MODIFY, 0, -32'sd5, 32'd0);
        send_item(ACT_MODIFY, 0, 32'sd77, 32'd0);
        send_item(ACT_MODIFY, 1, 32'sd77, 32'd40);
        send_item(ACT_MODIFY, 1, 32'sd77, 32'd60);
        send_item(ACT_EXEC, 1, 32'sd77, 32'd10);
        send_item(ACT_EXEC, 1, 32'sd77, 32'd50);
        send_item(ACT_EXEC, 0, 32'sd1234, 32'd1);
        send_item(ACT_REMOVE, 1, 32'sd1234, 32'd0);
        send_item(ACT_ADD, 1, 32'sd10, 32'd0);
        send_item(ACT_ADD, 0, 32'sd10, 32'd0);
        send_item(3'd5, 0, 32'sd0, 32'd0);
        send_item(3'd6, 1, 32'sd0, 32'd0);
        send_item(3'd7, 1, 32'sd0, 32'd0);
        send_item(ACT_CLEAR, 0, 32'sd0, 32'd0);

        // fill the bid table past its capacity, then the ask table
        for (int s = 0; s < 2; s++)
            for (int i = 0; i <= LEVELS; i++)
                send_item(ACT_ADD, s[0], 32'(i * 3 - 90), $urandom_range(1, 50));
        send_item(ACT_MODIFY, 1, 32'sd999, 32'd3);
        send_item(ACT_CLEAR, 1, 32'sd0, 32'd0);

        // random items with idle bursts, none in the last part
        allow_gaps = 1;
        for (int n = 0; n < 300; n++)
        begin
            if (n == 250) allow_gaps = 0;
            r = $urandom_range(0, 99);
            if (r < 40) act = ACT_ADD;
            else if (r < 60) act = ACT_MODIFY;
            else if (r < 72) act = ACT_REMOVE;
            else if (r < 92) act = ACT_EXEC;
            else if (r < 94) act = ACT_CLEAR;
            else act = 3'($urandom_range(5, 7));
            send_item(act, 1'($urandom_range(0, 1)), pick_price(), pick_qty());
        end
        start = 0;

        // drain, then let the block settle
        while (tob_pending != 0) @(negedge clk);
        repeat (2 * LEVELS + 20) @(negedge clk);
        $display("sent %0d items, checked %0d reports, %0d dropped inserts",
                 items_sent, tob_checked, drops_seen);
        if (fail_count == 0 && tob_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ price_level_order_book.f @@
sv/plob_pkg.sv
sv/plob_ctrl.sv
sv/plob_dp.sv
sv/price_level_order_book.sv
tb/price_level_order_book_checker.sv
tb/price_level_order_book_tb.sv
